[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property on the rising clock edge, off while reset is low.
`define LLWD_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Concurrent check that a condition leads to a consequence on the next clock edge.
`define LLWD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[sv/llwd_pkg.sv]
package llwd_pkg;

    // Field widths of the request and result channels.
    localparam int ACTION_W = 2;
    localparam int WORKER_W = 5;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 16;

    // Register port geometry.
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int REG_SEL_BIT = 2;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_ACQUIRE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ENABLED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 2'd2;
    localparam logic [STATUS_W-1:0] ST_AT_ZERO     = 2'd3;

    // Register indexes, decoded from the word address bit.
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    // Limit values.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 16'd20;
    localparam logic [LIMIT_W-1:0] FIXED_DEFAULT = 16'd20;
    localparam logic [LIMIT_W-1:0] GROW_DEFAULT  = 16'd100;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic start;
        logic scan_init;
        logic scan_read;
        logic acq_commit;
        logic rel_read;
        logic rel_commit;
        logic clear;
        logic res_echo;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                started;
        logic                scan_last;
    } dp_stat_t;

endpackage

[sv/llwd_ram.sv]
module llwd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/llwd_ctrl.sv]
module llwd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output llwd_pkg::ctrl_cmd_t  cmd,
    input  llwd_pkg::dp_stat_t   sts
);

    import llwd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_REL_CHECK,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // One request: decode, slot scan or single read and commit as needed, hand off.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.res_echo = 1'b1;
                case (sts.action)
                    ACT_ACQUIRE:
                    begin
                        cmd.start     = !sts.started;
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    ACT_RELEASE:
                    begin
                        cmd.rel_read = 1'b1;
                        state_next   = S_REL_CHECK;
                    end
                    ACT_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_read = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.acq_commit = 1'b1;
                state_next     = S_FINISH;
            end
            S_REL_CHECK:
            begin
                cmd.rel_commit = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                // Wait until the output register is free or being emptied.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag follows loads and downstream acceptance.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[sv/llwd_dpath.sv]
module llwd_dpath #(
    parameter int NUM_SLOTS  = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  llwd_pkg::ctrl_cmd_t               cmd,
    output llwd_pkg::dp_stat_t                sts,
    input  logic                              mode,
    input  logic [llwd_pkg::LIMIT_W-1:0]      limit,
    input  logic [llwd_pkg::ACTION_W-1:0]     action,
    input  logic [llwd_pkg::WORKER_W-1:0]     worker,
    output logic [llwd_pkg::WORKER_W-1:0]     chosen,
    output logic [llwd_pkg::STATUS_W-1:0]     status,
    output logic                              retired,
    output logic                              created
);

    import llwd_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int LIVE_W = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W  = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    // Captured request.
    logic [ACTION_W-1:0] action_reg;
    logic [WORKER_W-1:0] worker_reg;

    // Pool state.
    logic                 started_reg, started_next;
    logic                 run_mode_reg, run_mode_next;
    logic [LIMIT_W-1:0]   run_limit_reg, run_limit_next;
    logic [NUM_SLOTS-1:0] en_reg, en_next;
    logic [LIVE_W-1:0]    live_reg, live_next;
    logic [NUM_SLOTS-1:0] cnt_vld_reg, cnt_vld_next;

    // Scan pipeline and candidates.
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic                  pipe_vld_reg;
    logic [SLOT_W-1:0]     pipe_idx_reg;
    logic                  rd_vbit_reg;
    logic                  found_reg, found_next;
    logic [SLOT_W-1:0]     best_idx_reg, best_idx_next;
    logic [COUNT_BITS-1:0] best_cnt_reg, best_cnt_next;
    logic                  hit_found_reg, hit_found_next;
    logic [SLOT_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg, hit_cnt_next;
    logic                  free_found_reg, free_found_next;
    logic [SLOT_W-1:0]     free_idx_reg, free_idx_next;

    // Pending result and output register.
    logic [WORKER_W-1:0] res_chosen_reg, res_chosen_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_retired_reg, res_retired_next;
    logic                res_created_reg, res_created_next;
    logic [WORKER_W-1:0] chosen_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                retired_reg;
    logic                created_reg;

    // Count memory ports.
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [SLOT_W-1:0]     ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] rd_cnt;

    // Derived values.
    logic [LIMIT_W-1:0]   n_fixed;
    logic [LIMIT_W-1:0]   grow_lim;
    logic [NUM_SLOTS-1:0] fixed_en;
    logic [LIVE_W-1:0]    fixed_live;
    logic [SLOT_W-1:0]    widx;
    logic                 worker_ok;
    logic                 rel_bad;
    logic                 pipe_en;

    llwd_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // An entry not written since reset or clear reads as zero.
    assign rd_cnt = rd_vbit_reg ? ram_rdata : '0;

    // Pool size and cap with the zero default applied.
    assign n_fixed    = (limit == '0) ? FIXED_DEFAULT : limit;
    assign grow_lim   = (limit == '0) ? GROW_DEFAULT : limit;
    assign fixed_live = (32'(n_fixed) > 32'(NUM_SLOTS)) ? LIVE_W'(NUM_SLOTS) : LIVE_W'(n_fixed);

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            fixed_en[i] = (32'(i) < 32'(n_fixed));
        end
    end

    // Release target checks.
    assign widx      = SLOT_W'(worker_reg);
    assign worker_ok = (32'(worker_reg) < 32'(NUM_SLOTS));
    assign rel_bad   = !started_reg || !worker_ok || !en_reg[widx];

    // Read port: scan address or the release target.
    assign ram_re    = cmd.scan_read || cmd.rel_read;
    assign ram_raddr = cmd.scan_read ? idx_reg : widx;
    assign idx_next  = cmd.scan_init ? '0 : (cmd.scan_read ? idx_reg + 1'b1 : idx_reg);

    // Candidate tracking as scan data returns, one slot per cycle.
    assign pipe_en = en_reg[pipe_idx_reg];

    always_comb
    begin
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_cnt_next   = best_cnt_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        if (cmd.scan_init)
        begin
            found_next      = 1'b0;
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
        end
        else if (pipe_vld_reg)
        begin
            // Least loaded: strict compare keeps the lowest index on a tie.
            if (pipe_en && (!found_reg || rd_cnt < best_cnt_reg))
            begin
                found_next    = 1'b1;
                best_idx_next = pipe_idx_reg;
                best_cnt_next = rd_cnt;
            end
            // First fit below the cap.
            if (pipe_en && !hit_found_reg && (CMP_W'(rd_cnt) < CMP_W'(run_limit_reg))
                && (rd_cnt != COUNT_MAX))
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = pipe_idx_reg;
                hit_cnt_next   = rd_cnt;
            end
            // First free slot.
            if (!pipe_en && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = pipe_idx_reg;
            end
        end
    end

    // Pool start, count writes, enable changes and result formation.
    always_comb
    begin
        started_next     = started_reg;
        run_mode_next    = run_mode_reg;
        run_limit_next   = run_limit_reg;
        en_next          = en_reg;
        live_next        = live_reg;
        cnt_vld_next     = cnt_vld_reg;
        ram_we           = 1'b0;
        ram_waddr        = widx;
        ram_wdata        = rd_cnt - 1'b1;
        res_chosen_next  = res_chosen_reg;
        res_status_next  = res_status_reg;
        res_retired_next = res_retired_reg;
        res_created_next = res_created_reg;

        if (cmd.res_echo)
        begin
            res_chosen_next  = worker_reg;
            res_status_next  = ST_OK;
            res_retired_next = 1'b0;
            res_created_next = 1'b0;
        end

        // First acquire latches mode and limit and enables the initial pool.
        if (cmd.start)
        begin
            started_next  = 1'b1;
            run_mode_next = mode;
            if (!mode)
            begin
                run_limit_next = n_fixed;
                en_next        = fixed_en;
                live_next      = fixed_live;
            end
            else
            begin
                run_limit_next = grow_lim;
                en_next        = {{(NUM_SLOTS - 1){1'b0}}, 1'b1};
                live_next      = LIVE_W'(1);
            end
        end

        if (cmd.clear)
        begin
            cnt_vld_next = '0;
        end

        if (cmd.acq_commit)
        begin
            if (!run_mode_reg)
            begin
                res_chosen_next = WORKER_W'(best_idx_reg);
                if (!found_reg || best_cnt_reg == COUNT_MAX)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = best_idx_reg;
                    ram_wdata = best_cnt_reg + 1'b1;
                end
            end
            else if (hit_found_reg)
            begin
                res_chosen_next = WORKER_W'(hit_idx_reg);
                ram_we          = 1'b1;
                ram_waddr       = hit_idx_reg;
                ram_wdata       = hit_cnt_reg + 1'b1;
            end
            else if (free_found_reg)
            begin
                res_chosen_next       = WORKER_W'(free_idx_reg);
                res_created_next      = 1'b1;
                ram_we                = 1'b1;
                ram_waddr             = free_idx_reg;
                ram_wdata             = COUNT_BITS'(1);
                en_next[free_idx_reg] = 1'b1;
                live_next             = live_reg + 1'b1;
            end
            else
            begin
                res_chosen_next = '0;
                res_status_next = ST_FULL;
            end
        end

        if (cmd.rel_commit)
        begin
            if (rel_bad)
            begin
                res_status_next = ST_NOT_ENABLED;
            end
            else if (rd_cnt == '0)
            begin
                res_status_next = ST_AT_ZERO;
            end
            else
            begin
                ram_we    = 1'b1;
                ram_waddr = widx;
                ram_wdata = rd_cnt - 1'b1;
                // An idle grow-mode worker retires while others remain.
                if (run_mode_reg && rd_cnt == COUNT_BITS'(1) && live_reg > LIVE_W'(1))
                begin
                    en_next[widx]    = 1'b0;
                    live_next        = live_reg - 1'b1;
                    res_retired_next = 1'b1;
                end
            end
        end

        if (ram_we)
        begin
            cnt_vld_next[ram_waddr] = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            run_mode_reg   <= 1'b0;
            en_reg         <= '0;
            live_reg       <= '0;
            cnt_vld_reg    <= '0;
            idx_reg        <= '0;
            pipe_vld_reg   <= 1'b0;
            rd_vbit_reg    <= 1'b0;
            found_reg      <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            started_reg    <= started_next;
            run_mode_reg   <= run_mode_next;
            en_reg         <= en_next;
            live_reg       <= live_next;
            cnt_vld_reg    <= cnt_vld_next;
            idx_reg        <= idx_next;
            pipe_vld_reg   <= cmd.scan_read;
            found_reg      <= found_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            if (ram_re)
            begin
                rd_vbit_reg <= cnt_vld_reg[ram_raddr];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            worker_reg <= worker;
        end
        run_limit_reg   <= run_limit_next;
        pipe_idx_reg    <= idx_reg;
        best_idx_reg    <= best_idx_next;
        best_cnt_reg    <= best_cnt_next;
        hit_idx_reg     <= hit_idx_next;
        hit_cnt_reg     <= hit_cnt_next;
        free_idx_reg    <= free_idx_next;
        res_chosen_reg  <= res_chosen_next;
        res_status_reg  <= res_status_next;
        res_retired_reg <= res_retired_next;
        res_created_reg <= res_created_next;
        if (cmd.out_load)
        begin
            chosen_reg  <= res_chosen_reg;
            status_reg  <= res_status_reg;
            retired_reg <= res_retired_reg;
            created_reg <= res_created_reg;
        end
    end

    assign sts.action    = action_reg;
    assign sts.started   = started_reg;
    assign sts.scan_last = (idx_reg == LAST_SLOT);

    assign chosen  = chosen_reg;
    assign status  = status_reg;
    assign retired = retired_reg;
    assign created = created_reg;

endmodule

[sv/least_loaded_worker_dispatcher.sv]
// One request in flight; the next is taken in the cycle after the result is registered, and an
// acquire includes the one-slot-per-cycle scan of the count memory.
// Reset clears control state, enables and per-slot count valid bits at once, so every count
// reads as zero after reset with no clearing pass; mode resets to 0 and limit to 20.
module least_loaded_worker_dispatcher #(
    parameter int NUM_SLOTS  = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [llwd_pkg::ADDR_W-1:0]       paddr,
    input  logic [llwd_pkg::DATA_W-1:0]       pwdata,
    output logic [llwd_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [llwd_pkg::ACTION_W-1:0]     action,
    input  logic [llwd_pkg::WORKER_W-1:0]     worker,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [llwd_pkg::WORKER_W-1:0]     chosen,
    output logic [llwd_pkg::STATUS_W-1:0]     status,
    output logic                              retired,
    output logic                              created
);

    import llwd_pkg::*;

    logic               mode_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               cfg_wr;
    logic               reg_sel;
    ctrl_cmd_t          cmd;
    dp_stat_t           sts;

    // Register file: word address bit selects mode or limit.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[REG_SEL_BIT];
    assign prdata  = (reg_sel == REG_LIMIT) ? DATA_W'(limit_reg) : DATA_W'(mode_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == REG_MODE)
            begin
                mode_reg <= pwdata[0];
            end
            else
            begin
                limit_reg <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    llwd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    llwd_dpath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .mode    (mode_reg),
        .limit   (limit_reg),
        .action  (action),
        .worker  (worker),
        .chosen  (chosen),
        .status  (status),
        .retired (retired),
        .created (created)
    );

endmodule

[sv/llwd_checker.sv]
`include "assert_macros.svh"

module llwd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [llwd_pkg::WORKER_W-1:0] chosen,
    input logic [llwd_pkg::STATUS_W-1:0] status,
    input logic                          retired,
    input logic                          created
);

    import llwd_pkg::*;

    // The block is busy right after it takes a request.
    `LLWD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "request accepted while not busy afterward")

    // A result appears only at the end of busy processing.
    `LLWD_ASSERT(a_result_from_work, clk, rst_n, $rose(out_valid) |-> $past(in_stall), "result appeared without a request in progress")

    // A stalled result stays put.
    `LLWD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(chosen) && $stable(status), "stalled result changed")

    // Worker creation and retirement only come with a good status and never together.
    `LLWD_ASSERT(a_event_flags, clk, rst_n, out_valid && (retired || created) |-> (status == ST_OK) && !(retired && created), "bad event flags on result")

endmodule

bind least_loaded_worker_dispatcher llwd_checker u_llwd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .chosen    (chosen),
    .status    (status),
    .retired   (retired),
    .created   (created)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import llwd_pkg::*;

    localparam int SLOTS = 32;
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 155;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int REPORT_CAP = 100;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [WORKER_W-1:0] worker;
    } request_t;

    typedef struct packed {
        logic [WORKER_W-1:0] chosen;
        logic [STATUS_W-1:0] status;
        logic                retired;
        logic                created;
    } reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action = '0;
    logic [WORKER_W-1:0] worker = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [WORKER_W-1:0] chosen;
    logic [STATUS_W-1:0] status;
    logic                retired;
    logic                created;

    // Traffic control shared between the sequencer, the two handshake processes and the monitor.
    request_t pending_requests[$];
    reply_t   awaited_replies[$];
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    bit       long_hold_arm = 1'b0;
    bit       long_hold_done = 1'b0;
    int       send_gap_left = 0;
    int       recv_gap_left = 0;
    int       long_hold_left = 0;
    request_t next_request;
    reply_t   oldest_reply;
    int       mismatch_count = 0;
    int       replies_seen = 0;
    int unsigned cycle_count = 0;

    // Mirror of the dispatcher: registers, latched run settings and per-slot state.
    bit                 reg_mode = 1'b0;
    logic [LIMIT_W-1:0] reg_limit = LIMIT_RESET;
    bit                 pool_live = 1'b0;
    bit                 pool_grow = 1'b0;
    int unsigned        pool_cap = 0;
    logic [CNT_W-1:0]   slot_load [SLOTS];
    bit                 slot_on [SLOTS];

    least_loaded_worker_dispatcher #(
        .NUM_SLOTS  (SLOTS),
        .COUNT_BITS (CNT_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .worker    (worker),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .chosen    (chosen),
        .status    (status),
        .retired   (retired),
        .created   (created)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Applies one request to the mirror and returns the reply it must produce.
    function automatic reply_t dispatch_step(logic [ACTION_W-1:0] act, logic [WORKER_W-1:0] w);
        reply_t      r;
        int          best;
        bit          found;
        int          live_slots;
        int unsigned span;
        r = '{chosen: w, status: ST_OK, retired: 1'b0, created: 1'b0};
        case (act)
            ACT_ACQUIRE:
            begin
                // The first acquire starts the pool with the settings in force now.
                if (!pool_live)
                begin
                    pool_grow = reg_mode;
                    if (!pool_grow)
                    begin
                        span = (reg_limit == 0) ? FIXED_DEFAULT : reg_limit;
                        if (span > SLOTS)
                            span = SLOTS;
                        pool_cap = span;
                        for (int i = 0; i < span; i++)
                        begin
                            slot_on[i] = 1'b1;
                            slot_load[i] = '0;
                        end
                    end
                    else
                    begin
                        pool_cap = (reg_limit == 0) ? GROW_DEFAULT : reg_limit;
                        slot_on[0] = 1'b1;
                        slot_load[0] = '0;
                    end
                    pool_live = 1'b1;
                end
                found = 1'b0;
                best = 0;
                if (!pool_grow)
                begin
                    // Least loaded enabled slot, lowest index on a tie.
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_on[i] && (!found || slot_load[i] < slot_load[best]))
                        begin
                            best = i;
                            found = 1'b1;
                        end
                    r.chosen = best[WORKER_W-1:0];
                    if (!found || slot_load[best] == CNT_MAX)
                        r.status = ST_FULL;
                    else
                        slot_load[best] = slot_load[best] + 1'b1;
                end
                else
                begin
                    // First enabled slot under the cap, else open the lowest free slot.
                    for (int i = 0; i < SLOTS; i++)
                        if (!found && slot_on[i] && slot_load[i] < pool_cap
                            && slot_load[i] != CNT_MAX)
                        begin
                            slot_load[i] = slot_load[i] + 1'b1;
                            r.chosen = i[WORKER_W-1:0];
                            found = 1'b1;
                        end
                    for (int i = 0; i < SLOTS; i++)
                        if (!found && !slot_on[i])
                        begin
                            slot_on[i] = 1'b1;
                            slot_load[i] = CNT_W'(1);
                            r.chosen = i[WORKER_W-1:0];
                            r.created = 1'b1;
                            found = 1'b1;
                        end
                    if (!found)
                    begin
                        r.chosen = '0;
                        r.status = ST_FULL;
                    end
                end
            end
            ACT_RELEASE:
            begin
                if (!pool_live || !slot_on[w])
                    r.status = ST_NOT_ENABLED;
                else if (slot_load[w] == 0)
                    r.status = ST_AT_ZERO;
                else
                begin
                    slot_load[w] = slot_load[w] - 1'b1;
                    // In grow mode an idle slot retires unless it is the last one.
                    if (pool_grow && slot_load[w] == 0)
                    begin
                        live_slots = 0;
                        for (int i = 0; i < SLOTS; i++)
                            live_slots += slot_on[i];
                        if (live_slots > 1)
                        begin
                            slot_on[w] = 1'b0;
                            r.retired = 1'b1;
                        end
                    end
                end
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    slot_load[i] = '0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic queue_request(input logic [ACTION_W-1:0] act, input logic [WORKER_W-1:0] w);
        request_t req;
        req.action = act;
        req.worker = w;
        pending_requests.push_back(req);
    endtask

    // Register write: setup cycle, then access cycle until pready is seen.
    task automatic write_register(input logic idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << REG_SEL_BIT;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MODE)
            reg_mode = value[0];
        else
            reg_limit = value[LIMIT_W-1:0];
    endtask

    // Blocks until every queued request was taken and every reply has come back.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || awaited_replies.size() != 0);
    endtask

    // Request sender: presents queued requests, with random idle bursts between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap_left = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (send_gap_left > 0)
            begin
                send_gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                next_request = pending_requests.pop_front();
                action <= next_request.action;
                worker <= next_request.worker;
                in_valid <= 1'b1;
                if ($urandom_range(0, 99) < send_idle_pct)
                    send_gap_left = $urandom_range(1, 12);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Reply receiver: random stall bursts and one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap_left = 0;
            long_hold_left = 0;
        end
        else if (long_hold_left > 0)
        begin
            long_hold_left--;
            out_stall <= 1'b1;
        end
        else if (long_hold_arm && !long_hold_done)
        begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (recv_gap_left > 0)
        begin
            recv_gap_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < recv_idle_pct)
        begin
            recv_gap_left = $urandom_range(0, 11);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor: predicts on each accepted request and checks each accepted reply.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                awaited_replies.push_back(dispatch_step(action, worker));
            if (out_valid && !out_stall)
            begin
                if (awaited_replies.size() == 0)
                    report_mismatch($sformatf("reply with none awaited: chosen %0d status %0d",
                                              chosen, status));
                else
                begin
                    oldest_reply = awaited_replies.pop_front();
                    if (chosen !== oldest_reply.chosen)
                        report_mismatch($sformatf("reply %0d chosen %0d, expected %0d",
                                                  replies_seen, chosen, oldest_reply.chosen));
                    if (status !== oldest_reply.status)
                        report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                                  replies_seen, status, oldest_reply.status));
                    if (retired !== oldest_reply.retired)
                        report_mismatch($sformatf("reply %0d retired %0b, expected %0b",
                                                  replies_seen, retired, oldest_reply.retired));
                    if (created !== oldest_reply.created)
                        report_mismatch($sformatf("reply %0d created %0b, expected %0b",
                                                  replies_seen, created, oldest_reply.created));
                end
                replies_seen++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int          pick;
        int          acq_pct;
        int          focus;
        logic [LIMIT_W-1:0] run_limit;
        bit          run_mode;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_load[i] = '0;
            slot_on[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Before the pool starts: extreme settings, releases, clear and the unused action.
        write_register(REG_MODE, DATA_W'({$urandom, 1'b1}));
        write_register(REG_LIMIT, DATA_W'({$urandom, 16'hFFFF}));
        queue_request(ACT_RELEASE, 5'd0);
        queue_request(ACT_RELEASE, 5'd31);
        queue_request(ACT_CLEAR, 5'd0);
        queue_request(ACT_UNUSED, 5'd31);
        wait_drained();
        write_register(REG_MODE, DATA_W'({$urandom, 1'b0}));
        write_register(REG_LIMIT, DATA_W'({$urandom, 16'h0000}));
        queue_request(ACT_CLEAR, 5'd31);
        queue_request(ACT_UNUSED, 5'd0);
        wait_drained();

        // The setting in force at the first acquire decides the whole run.
        run_mode = 1'($urandom_range(0, 1));
        if (run_mode)
            run_limit = LIMIT_W'($urandom_range(1, 3));
        else
        begin
            case ($urandom_range(0, 4))
                0: run_limit = LIMIT_W'(0);
                1: run_limit = LIMIT_W'(1);
                2: run_limit = LIMIT_W'($urandom_range(2, 31));
                3: run_limit = LIMIT_W'(SLOTS);
                default: run_limit = LIMIT_W'($urandom_range(SLOTS + 1, 65535));
            endcase
        end
        write_register(REG_MODE, DATA_W'({$urandom, run_mode}));
        write_register(REG_LIMIT, DATA_W'({$urandom, run_limit}));

        // Directed requests once the pool is running.
        repeat (4) queue_request(ACT_ACQUIRE, WORKER_W'($urandom));
        queue_request(ACT_RELEASE, 5'd0);
        queue_request(ACT_RELEASE, 5'd0);
        queue_request(ACT_RELEASE, 5'd31);
        queue_request(ACT_RELEASE, 5'd1);
        queue_request(ACT_CLEAR, 5'd0);
        queue_request(ACT_RELEASE, 5'd0);
        queue_request(ACT_ACQUIRE, 5'd31);
        queue_request(ACT_RELEASE, 5'd0);
        queue_request(ACT_UNUSED, 5'd21);
        repeat (3) queue_request(ACT_ACQUIRE, WORKER_W'($urandom));
        wait_drained();

        // Random phases: fill, drain and balanced traffic with random content.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1 || p % 4 == 2)
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            else
            begin
                send_idle_pct <= $urandom_range(10, 40);
                recv_idle_pct <= $urandom_range(10, 40);
            end
            if (p == 3)
                long_hold_arm <= 1'b1;
            case (p % 3)
                0: acq_pct = 75;
                1: acq_pct = 25;
                default: acq_pct = 48;
            endcase
            case ($urandom_range(0, 3))
                0: focus = 3;
                1: focus = 7;
                2: focus = 15;
                default: focus = 31;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    queue_request(ACT_CLEAR, WORKER_W'($urandom));
                else if (pick < 4)
                    queue_request(ACT_UNUSED, WORKER_W'($urandom));
                else if (pick < 4 + acq_pct)
                    queue_request(ACT_ACQUIRE, WORKER_W'($urandom));
                else if ($urandom_range(0, 9) < 7)
                    queue_request(ACT_RELEASE, WORKER_W'($urandom_range(0, focus)));
                else
                    queue_request(ACT_RELEASE, WORKER_W'($urandom));
            end
            wait_drained();

            // The pool has latched its settings; these writes must leave behavior alone.
            if (p < PHASES - 1)
            begin
                write_register(REG_MODE, $urandom);
                case ($urandom_range(0, 2))
                    0: write_register(REG_LIMIT, DATA_W'({$urandom, 16'h0000}));
                    1: write_register(REG_LIMIT, DATA_W'({$urandom, 16'hFFFF}));
                    default: write_register(REG_LIMIT, $urandom);
                endcase
            end
        end

        repeat (SLOTS + 10) @(posedge clk);
        if (mismatch_count == 0 && awaited_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/llwd_pkg.sv
sv/llwd_ram.sv
sv/llwd_ctrl.sv
sv/llwd_dpath.sv
sv/least_loaded_worker_dispatcher.sv
sv/llwd_checker.sv
tb/testbench.sv
